// ----- rtl/core/crcfc_pkg.sv -----
// Package: widths, configuration reset values and register index codes of the CRC-16 frame checker.
`default_nettype none

package crcfc_pkg;

   localparam int BYTE_W  = 8;
   localparam int CRC_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int HELD_CNT_W = 2;

   localparam logic [CRC_W-1:0] POLY_RESET  = 16'hA001;
   localparam logic [CRC_W-1:0] START_RESET = 16'hFFFF;
   localparam logic             HBF_RESET   = 1'b0;
   localparam logic             CHECK_RESET = 1'b1;

   // number of trailing bytes held back as the received CRC
   localparam logic [HELD_CNT_W-1:0] HELD_FULL = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POLYNOMIAL      = 2'd0,
      CSR_START_VALUE     = 2'd1,
      CSR_HIGH_BYTE_FIRST = 2'd2,
      CSR_CHECK_MODE      = 2'd3
   } csr_index_type;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CRC_W-1:0]  crc_type;

endpackage

`default_nettype wire

// ----- rtl/core/crcfc_if.sv -----
// Interfaces: request (frame byte) and response (CRC verdict) channels.
`default_nettype none

interface crcfc_req_if;
   import crcfc_pkg::*;
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     frame_end;

   modport source (output valid, output data_byte, output frame_end, input ready);
   modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface crcfc_rsp_if;
   import crcfc_pkg::*;
   logic    valid;
   logic    ready;
   crc_type crc_result;
   logic    frame_ok;
   logic    too_short;

   modport source (output valid, output crc_result, output frame_ok, output too_short,
                   input ready);
   modport sink   (input valid, input crc_result, input frame_ok, input too_short,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/core/crc16_frame_checker.sv -----
// Top level: CRC-16 frame checker with input register, byte fold and result register.
//
//   channel   direction  handshake          payload
//   req       in         valid/ready        data_byte[7:0], frame_end
//   rsp       out        valid/ready        crc_result[15:0], frame_ok, too_short
//   csr       in         csr_wr_en only     csr_index[1:0], csr_wdata[15:0]
//
// One byte per cycle sustained. A byte is registered at acceptance and folded
// or held back as it advances, where a final byte loads the result register.
// Synchronous active-high reset restores register defaults and idles the frame.
// Only a final byte waits on a full result register; other bytes never stall on rsp.
// The throughput is set by the single 8-step fold between crc state and its next value.
`default_nettype none

module crc16_frame_checker (
   input  wire                          clock,
   input  wire                          reset,
   crcfc_req_if.sink                    req_chan,
   crcfc_rsp_if.source                  rsp_chan,
   input  wire                          csr_wr_en,
   input  wire crcfc_pkg::csr_index_type csr_index,
   input  wire crcfc_pkg::crc_type      csr_wdata
);
   import crcfc_pkg::*;

   // configuration
   crc_type poly_ff, start_ff;
   logic    hbf_ff, check_ff;

   // input register
   logic     in_valid_ff;
   byte_type in_byte_ff;
   logic     in_last_ff;

   // frame state
   logic                  in_frame_ff, in_frame_in;
   crc_type               crc_ff, crc_in;
   byte_type              held0_ff, held0_in, held1_ff, held1_in;
   logic [HELD_CNT_W-1:0] held_cnt_ff, held_cnt_in;

   // result register
   logic    out_valid_ff;
   crc_type out_crc_ff, out_crc_in;
   logic    out_ok_ff, out_ok_in, out_short_ff, out_short_in;

   logic     advance, out_free, held_full;
   crc_type  crc_base, fold_out, received;
   byte_type fold_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff  <= POLY_RESET;
         start_ff <= START_RESET;
         hbf_ff   <= HBF_RESET;
         check_ff <= CHECK_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_POLYNOMIAL:      poly_ff  <= csr_wdata;
            CSR_START_VALUE:     start_ff <= csr_wdata;
            CSR_HIGH_BYTE_FIRST: hbf_ff   <= csr_wdata[0];
            CSR_CHECK_MODE:      check_ff <= csr_wdata[0];
         endcase
      end
   end

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   // non-final bytes produce no result and never wait
   assign advance        = in_valid_ff && (!in_last_ff || out_free);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.frame_end;
      end
   end

   assign crc_base  = in_frame_ff ? crc_ff : start_ff;
   assign held_full = (held_cnt_ff == HELD_FULL);
   assign fold_byte = check_ff ? held0_ff : in_byte_ff;

   crcfc_byte_fold u_fold (
      .crc_cur  (crc_base),
      .data     (fold_byte),
      .poly     (poly_ff),
      .crc_next (fold_out)
   );

   always_comb begin
      in_frame_in  = in_frame_ff;
      crc_in       = crc_ff;
      held0_in     = held0_ff;
      held1_in     = held1_ff;
      held_cnt_in  = held_cnt_ff;
      out_crc_in   = out_crc_ff;
      out_ok_in    = out_ok_ff;
      out_short_in = out_short_ff;
      received     = {held1_ff, held0_ff};
      if (advance) begin
         in_frame_in = 1'b1;
         if (check_ff) begin
            if (held_full) begin
               crc_in   = fold_out;
               held0_in = held1_ff;
               held1_in = in_byte_ff;
            end else begin
               crc_in      = crc_base;
               held_cnt_in = held_cnt_ff + 1'b1;
               if (held_cnt_ff[0]) begin
                  held1_in = in_byte_ff;
               end else begin
                  held0_in = in_byte_ff;
               end
            end
         end else begin
            crc_in = fold_out;
         end
         received = hbf_ff ? {held0_in, held1_in} : {held1_in, held0_in};
         if (in_last_ff) begin
            out_crc_in   = crc_in;
            out_short_in = check_ff && (held_cnt_in != HELD_FULL);
            out_ok_in    = check_ff && (held_cnt_in == HELD_FULL) && (received == crc_in);
            in_frame_in  = 1'b0;
            held_cnt_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         held_cnt_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
         held_cnt_ff <= held_cnt_in;
         if (advance && in_last_ff) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      crc_ff       <= crc_in;
      held0_ff     <= held0_in;
      held1_ff     <= held1_in;
      out_crc_ff   <= out_crc_in;
      out_ok_ff    <= out_ok_in;
      out_short_ff <= out_short_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.crc_result = out_crc_ff;
   assign rsp_chan.frame_ok   = out_ok_ff;
   assign rsp_chan.too_short  = out_short_ff;

endmodule

`default_nettype wire

// ----- rtl/core/crcfc_byte_fold.sv -----
// Byte fold: one reflected, LSB-first CRC-16 update over eight bits.
`default_nettype none

module crcfc_byte_fold (
   input  wire crcfc_pkg::crc_type  crc_cur,
   input  wire crcfc_pkg::byte_type data,
   input  wire crcfc_pkg::crc_type  poly,
   output crcfc_pkg::crc_type       crc_next
);
   import crcfc_pkg::*;

   crc_type acc;

   always_comb begin
      acc = crc_cur ^ {{(CRC_W-BYTE_W){1'b0}}, data};
      for (int k = 0; k < BYTE_W; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ poly;
         end else begin
            acc = acc >> 1;
         end
      end
      crc_next = acc;
   end

endmodule

`default_nettype wire

// ----- bench/crcfc_tb_pkg.sv -----
// Scoreboard package for the CRC-16 frame checker bench: byte-level predictor and verdict queue.
package crcfc_tb_pkg;
   import crcfc_pkg::*;

   typedef struct packed {
      crc_type crc;
      logic    ok;
      logic    short_frame;
   } verdict_type;

   // reflected LSB-first update of one byte
   function automatic crc_type fold_byte(crc_type crc, byte_type b, crc_type poly);
      crc_type c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) c = (c >> 1) ^ poly;
         else c = c >> 1;
      end
      return c;
   endfunction

   class crc_scoreboard;
      crc_type     poly;
      crc_type     start;
      logic        hbf;
      logic        chk;
      crc_type     crc_acc;
      byte_type    held [2];
      int unsigned held_n;
      bit          in_frame;
      verdict_type verdicts [$];
      int          mismatches;
      int          checked;
      int          ok_count;
      int          short_count;

      function new();
         poly        = POLY_RESET;
         start       = START_RESET;
         hbf         = HBF_RESET;
         chk         = CHECK_RESET;
         crc_acc     = START_RESET;
         held[0]     = '0;
         held[1]     = '0;
         held_n      = 0;
         in_frame    = 1'b0;
         mismatches  = 0;
         checked     = 0;
         ok_count    = 0;
         short_count = 0;
      endfunction

      function void write_reg(csr_index_type idx, crc_type v);
         case (idx)
            CSR_POLYNOMIAL:      poly  = v;
            CSR_START_VALUE:     start = v;
            CSR_HIGH_BYTE_FIRST: hbf   = v[0];
            CSR_CHECK_MODE:      chk   = v[0];
            default: ;
         endcase
      endfunction

      // one accepted byte; a final byte queues the verdict it must produce
      function void note_byte(byte_type b, logic last);
         verdict_type v;
         crc_type     rx;
         if (!in_frame) begin
            crc_acc  = start;
            in_frame = 1'b1;
         end
         if (chk) begin
            // the two newest bytes stay held back as the received CRC
            if (held_n >= 2) begin
               crc_acc = fold_byte(crc_acc, held[0], poly);
               held[0] = held[1];
               held[1] = b;
            end else begin
               held[held_n] = b;
               held_n++;
            end
         end else begin
            crc_acc = fold_byte(crc_acc, b, poly);
         end
         if (last) begin
            v.crc         = crc_acc;
            v.ok          = 1'b0;
            v.short_frame = 1'b0;
            if (chk) begin
               if (held_n < 2) begin
                  v.short_frame = 1'b1;
               end else begin
                  rx   = hbf ? {held[0], held[1]} : {held[1], held[0]};
                  v.ok = (rx == crc_acc);
               end
            end
            verdicts.push_back(v);
            held[0]  = '0;
            held[1]  = '0;
            held_n   = 0;
            in_frame = 1'b0;
         end
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 50) $display("MISMATCH %0d: %s", mismatches, msg);
      endtask

      task check_verdict(crc_type crc, logic ok, logic short_frame);
         verdict_type want;
         if (verdicts.size() == 0) begin
            report($sformatf("verdict with none pending: crc=%h ok=%b short=%b",
                             crc, ok, short_frame));
         end else begin
            want = verdicts.pop_front();
            checked++;
            if (want.ok) ok_count++;
            if (want.short_frame) short_count++;
            if (crc !== want.crc)
               report($sformatf("verdict %0d crc_result %h, want %h", checked, crc, want.crc));
            if (ok !== want.ok)
               report($sformatf("verdict %0d frame_ok %b, want %b", checked, ok, want.ok));
            if (short_frame !== want.short_frame)
               report($sformatf("verdict %0d too_short %b, want %b", checked, short_frame,
                                want.short_frame));
         end
      endtask
   endclass

endpackage

// ----- bench/tb.sv -----
// Testbench top: drives frames through the CRC-16 frame checker and scores every verdict.
module tb;
   import crcfc_pkg::*;
   import crcfc_tb_pkg::*;

   localparam int RANDOM_PER_PHASE = 160;
   localparam int HOLD_AT          = 800;
   localparam int HOLD_CYCLES      = 300;
   localparam int CYCLE_LIMIT      = 200000;

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_wr_en;
   csr_index_type csr_index;
   crc_type       csr_wdata;

   crcfc_req_if req_chan ();
   crcfc_rsp_if rsp_chan ();

   crc16_frame_checker DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   crc_scoreboard sb = new();

   int       send_idle_pct;
   int       rsp_idle_pct;
   int       bytes_sent;
   int       frames_sent;
   int       cycles;
   byte_type frame_buf [$];

   always #10 clock = ~clock;

   task send_byte(byte_type b, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      req_chan.frame_end <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_byte(b, last);
      bytes_sent++;
   endtask

   task send_frame();
      foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
      frames_sent++;
   endtask

   // appends the CRC of frame_buf in the byte order currently configured
   task append_crc();
      crc_type c;
      c = sb.start;
      foreach (frame_buf[i]) c = fold_byte(c, frame_buf[i], sb.poly);
      if (sb.hbf) begin
         frame_buf.push_back(c[15:8]);
         frame_buf.push_back(c[7:0]);
      end else begin
         frame_buf.push_back(c[7:0]);
         frame_buf.push_back(c[15:8]);
      end
   endtask

   task random_frame();
      int len;
      int pick;
      int pos;
      frame_buf.delete();
      pick = $urandom_range(19);
      if (pick < 2) len = $urandom_range(2, 1);
      else if (pick == 19) len = $urandom_range(48, 17);
      else len = $urandom_range(16, 3);
      if (sb.chk && len >= 2) begin
         repeat (len - 2) frame_buf.push_back(byte_type'($urandom));
         append_crc();
         // mostly good frames; some with a flipped bit or a garbage trailer
         pick = $urandom_range(9);
         if (pick == 0) begin
            pos = $urandom_range(len - 1);
            frame_buf[pos] = frame_buf[pos] ^ byte_type'(1 << $urandom_range(7));
         end else if (pick == 1) begin
            frame_buf[len - 1] = byte_type'($urandom);
         end
      end else begin
         repeat (len) frame_buf.push_back(byte_type'($urandom));
      end
      send_frame();
   endtask

   task wait_drained();
      req_chan.valid <= 1'b0;
      while (sb.verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task configure(crc_type poly, crc_type start, logic hbf, logic chk);
      crc_type vals [4];
      // 1-bit registers get random upper bits, which must be ignored
      vals[0] = poly;
      vals[1] = start;
      vals[2] = crc_type'($urandom << 1) | crc_type'(hbf);
      vals[3] = crc_type'($urandom << 1) | crc_type'(chk);
      csr_wr_en <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= csr_index_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.write_reg(csr_index_type'(i), vals[i]);
      end
      csr_wr_en <= 1'b0;
   endtask

   // result side: checks each item, idles at random, one long hold-off
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            sb.check_verdict(rsp_chan.crc_result, rsp_chan.frame_ok, rsp_chan.too_short);
         if (!hold_done && bytes_sent >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles, %0d verdicts pending", cycles, sb.verdicts.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int       phase;
      int       phase_start;
      byte_type tmp;
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_index          <= CSR_POLYNOMIAL;
      csr_wdata          <= '0;
      req_chan.valid     <= 1'b0;
      req_chan.data_byte <= '0;
      req_chan.frame_end <= 1'b0;
      rsp_chan.ready     <= 1'b0;
      send_idle_pct = 8;
      rsp_idle_pct  = 73;
      bytes_sent    = 0;
      frames_sent   = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames under reset defaults
      frame_buf = '{8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h01};
      append_crc();
      send_frame();
      // CRC bytes sent in the wrong order
      frame_buf = '{8'hFF, 8'h00, 8'h80, 8'h7F};
      append_crc();
      tmp = frame_buf[5];
      frame_buf[5] = frame_buf[4];
      frame_buf[4] = tmp;
      send_frame();
      // one byte: too short to carry a CRC
      frame_buf = '{8'hFF};
      send_frame();
      // two bytes: CRC of nothing is the start value
      frame_buf = '{8'hFF, 8'hFF};
      send_frame();
      frame_buf = '{8'h00, 8'h00};
      send_frame();
      frame_buf = '{8'h00};
      append_crc();
      send_frame();

      for (phase = 0; phase < 7; phase++) begin
         wait_drained();
         case (phase)
            0: configure(POLY_RESET, START_RESET, 1'b0, 1'b1);
            1: configure(POLY_RESET, START_RESET, 1'b1, 1'b1);
            2: configure(POLY_RESET, START_RESET, 1'b0, 1'b0);
            3: configure(16'h0000, 16'h0000, 1'b0, 1'b1);
            4: configure(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
            5: configure(crc_type'($urandom), crc_type'($urandom), 1'($urandom), 1'b0);
            default: configure(crc_type'($urandom), crc_type'($urandom), 1'($urandom), 1'b1);
         endcase
         if (phase < 2) begin
            send_idle_pct = 8;
            rsp_idle_pct  = 73;
         end else if (phase < 4) begin
            send_idle_pct = 73;
            rsp_idle_pct  = 8;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < RANDOM_PER_PHASE) random_frame();
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Sent %0d bytes in %0d frames across reset defaults and 7 register settings",
               bytes_sent, frames_sent);
      $display("Checked %0d verdicts (%0d CRC matches, %0d short frames), %0d mismatches",
               sb.checked, sb.ok_count, sb.short_count, sb.mismatches);
      if (sb.mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
